@@ design/assert_macros.svh @@
// Assertion macros shared by the bump debounce and scaler design.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that a boolean condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ design/bdss_pkg.sv @@
// Package for the bump debounce, slew and speed scaler block.
// Holds configuration types, register indexes, reset values and constants.
package bdss_pkg;

	localparam int SCALE_W = 7;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;
	localparam int RAW_W   = 8;
	localparam int DRV_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x below 43690
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int FAC_W       = 20;

	localparam logic [RAW_W:0] STICK_CENTRE = 9'd128;

	localparam logic [SCALE_W-1:0] RST_DEADZONE  = 7'd10;
	localparam logic [DEB_W-1:0]   RST_DEBOUNCE  = 16'd50;
	localparam logic [SCALE_W-1:0] RST_COLLISION = 7'd40;
	localparam logic [SCALE_W-1:0] RST_NORMAL    = 7'd100;
	localparam logic [SCALE_W-1:0] RST_STEP      = 7'd12;

	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_JOY  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE  = 3'd0,
		REG_DEBOUNCE  = 3'd1,
		REG_COLLISION = 3'd2,
		REG_NORMAL    = 3'd3,
		REG_STEP      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SCALE_W-1:0] deadzone;
		logic [DEB_W-1:0]   debounce_ms;
		logic [SCALE_W-1:0] bumped_pct;
		logic [SCALE_W-1:0] clear_pct;
		logic [SCALE_W-1:0] slew_step;
	} cfg_t;

endpackage

@@ design/bdss_req_if.sv @@
// Request channel: valid/ready handshake carrying a poll tick or stick sample.
// Uses widths from bdss_pkg.
interface bdss_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [bdss_pkg::TIME_W-1:0]     now_ms;
	logic                            right_switch_level;
	logic                            left_switch_level;
	logic [bdss_pkg::RAW_W-1:0]      left_stick_raw;
	logic [bdss_pkg::RAW_W-1:0]      right_stick_raw;

	modport source (
		output valid, req_type, now_ms, right_switch_level, left_switch_level,
			left_stick_raw, right_stick_raw,
		input  ready
	);
	modport sink (
		input  valid, req_type, now_ms, right_switch_level, left_switch_level,
			left_stick_raw, right_stick_raw,
		output ready
	);
endinterface

@@ design/bdss_res_if.sv @@
// Result channel: valid/ready handshake carrying scales and drive commands.
// Uses widths from bdss_pkg.
interface bdss_res_if;
	logic                                valid;
	logic                                ready;
	logic [bdss_pkg::SCALE_W-1:0]        left_scale_now;
	logic [bdss_pkg::SCALE_W-1:0]        right_scale_now;
	logic                                drive_valid;
	logic signed [bdss_pkg::DRV_W-1:0]   left_drive;
	logic signed [bdss_pkg::DRV_W-1:0]   right_drive;

	modport source (
		output valid, left_scale_now, right_scale_now, drive_valid,
			left_drive, right_drive,
		input  ready
	);
	modport sink (
		input  valid, left_scale_now, right_scale_now, drive_valid,
			left_drive, right_drive,
		output ready
	);
endinterface

@@ design/bdss_switch.sv @@
// One debounced bump switch with the target scale it sets for the far side.
// Depends on bdss_pkg.
module bdss_switch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            level,
	input  logic [bdss_pkg::TIME_W-1:0]     now_ms,
	input  bdss_pkg::cfg_t                  cfg,
	output logic [bdss_pkg::SCALE_W-1:0]    target_nxt
);
	import bdss_pkg::*;

	logic                level_q;
	logic [TIME_W-1:0]   stamp_q;
	logic [SCALE_W-1:0]  target_q;
	logic [TIME_W-1:0]   elapsed;
	logic                take;

	// Elapsed time wraps modulo 2^32
	assign elapsed = now_ms - stamp_q;
	assign take = en && (level != level_q)
		&& (elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms});

	assign target_nxt = take ? (level ? cfg.clear_pct : cfg.bumped_pct) : target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b1;
			stamp_q  <= '0;
			target_q <= RST_NORMAL;
		end else if (take) begin
			level_q  <= level;
			stamp_q  <= now_ms;
			target_q <= target_nxt;
		end
	end
endmodule

@@ design/bdss_scale.sv @@
// Slew-limited scale of one motor side, with its registered divide factor.
// Depends on bdss_pkg.
module bdss_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [bdss_pkg::SCALE_W-1:0]    target,
	input  logic [bdss_pkg::SCALE_W-1:0]    step,
	output logic [bdss_pkg::SCALE_W-1:0]    scale,
	output logic [bdss_pkg::SCALE_W-1:0]    scale_nxt,
	output logic [bdss_pkg::FAC_W-1:0]      fac
);
	import bdss_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [FAC_W-1:0]   fac_q;
	logic [SCALE_W:0]   up;
	logic [SCALE_W:0]   lim;
	logic [SCALE_W-1:0] slewed;

	assign up  = {1'b0, scale_q} + {1'b0, step};
	assign lim = {1'b0, target} + {1'b0, step};

	// Move toward the target and clamp there
	always_comb begin
		if (scale_q < target) begin
			slewed = (up > {1'b0, target}) ? target : up[SCALE_W-1:0];
		end else if (scale_q > target) begin
			slewed = ({1'b0, scale_q} < lim) ? target : scale_q - step;
		end else begin
			slewed = scale_q;
		end
	end

	assign scale_nxt = en ? slewed : scale_q;
	assign scale     = scale_q;
	assign fac       = fac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= RST_NORMAL;
			fac_q   <= FAC_W'(RST_NORMAL) * FAC_W'(RECIP);
		end else if (en) begin
			scale_q <= slewed;
			fac_q   <= FAC_W'(slewed) * FAC_W'(RECIP);
		end
	end
endmodule

@@ design/bdss_drive.sv @@
// Centre, deadzone and scale one stick byte into a saturated signed command.
// Depends on bdss_pkg.
module bdss_drive (
	input  logic [bdss_pkg::RAW_W-1:0]        raw,
	input  logic [bdss_pkg::SCALE_W-1:0]      deadzone,
	input  logic [bdss_pkg::FAC_W-1:0]        fac,
	output logic signed [bdss_pkg::DRV_W-1:0] drive
);
	import bdss_pkg::*;

	localparam int PROD_W = RAW_W + FAC_W;
	localparam int Q_W    = PROD_W - RECIP_SHIFT;

	logic [RAW_W:0]   v;
	logic             neg;
	logic [RAW_W:0]   mag;
	logic [RAW_W-1:0] mag_eff;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0]   q;

	assign v   = {1'b0, raw} - STICK_CENTRE;
	assign neg = v[RAW_W];
	assign mag = neg ? (~v + 1'b1) : v;
	// Force zero inside the deadzone
	assign mag_eff = (mag < {2'b00, deadzone}) ? '0 : mag[RAW_W-1:0];
	assign prod = PROD_W'(mag_eff) * PROD_W'(fac);
	assign q    = prod[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (!neg) begin
			drive = (q > Q_W'(127)) ? 8'sd127 : signed'(q[DRV_W-1:0]);
		end else begin
			drive = (q > Q_W'(128)) ? -8'sd128 : signed'(DRV_W'(~q + 1'b1));
		end
	end
endmodule

@@ design/bump_debounce_slew_speed_scaler_core.sv @@
// Top level of the bump debounce, slew and speed scaler block.
// Depends on bdss_pkg, bdss_req_if, bdss_res_if, bdss_switch, bdss_scale,
// bdss_drive and assert_macros.svh.
//
// Usage:
//   req carries items of two kinds. A poll tick (req_type 0) brings both bump
//   switch levels and a millisecond stamp; a debounced change of the right
//   switch retargets the left scale and vice versa, then both scales slew one
//   step toward their targets. A joystick item (req_type 1) brings two stick
//   bytes, which are centred, deadzoned and scaled by the current side scale.
//   res returns exactly one item per request, in order.
//   Throughput: one item per cycle while res is ready; all state update and
//   scaling sits in the single stage between the input stage and the result
//   register, the widest path being one 8x20 multiply for the divide by 100.
//   Configuration is a plain write port; the user must write it only while
//   the block is idle, which the block itself does not enforce.
//   Reset: targets and scales return to 100, switches to released, stamps
//   to 0, registers to their defaults, both channels empty.
//   Stall: while res is held the result register keeps its item and one
//   more waits in the input stage; req drops ready only when both are full.
`include "assert_macros.svh"
module bump_debounce_slew_speed_scaler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bdss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdss_pkg::CFG_DATA_W-1:0]   cfg_data,
	bdss_req_if.sink                          req,
	bdss_res_if.source                        res
);
	import bdss_pkg::*;

	cfg_t cfg_q;

	// Input stage
	logic               valid_s1;
	logic               type_s1;
	logic [TIME_W-1:0]  now_s1;
	logic               rlev_s1;
	logic               llev_s1;
	logic [RAW_W-1:0]   lraw_s1;
	logic [RAW_W-1:0]   rraw_s1;

	// Result register
	logic                     res_valid_q;
	logic [SCALE_W-1:0]       lscale_q;
	logic [SCALE_W-1:0]       rscale_q;
	logic                     dvalid_q;
	logic signed [DRV_W-1:0]  ldrive_q;
	logic signed [DRV_W-1:0]  rdrive_q;

	logic advance;
	logic poll_en;
	logic [SCALE_W-1:0] left_tgt_nxt, right_tgt_nxt;
	logic [SCALE_W-1:0] left_scale, right_scale;
	logic [SCALE_W-1:0] left_scale_nxt, right_scale_nxt;
	logic [FAC_W-1:0]   left_fac, right_fac;
	logic signed [DRV_W-1:0] left_drv, right_drv;

	// Advance the input stage whenever the result register is free or drains
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign poll_en   = advance && (type_s1 == REQ_POLL);

	// Configuration writes; drop unlisted indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone    <= RST_DEADZONE;
			cfg_q.debounce_ms <= RST_DEBOUNCE;
			cfg_q.bumped_pct  <= RST_COLLISION;
			cfg_q.clear_pct   <= RST_NORMAL;
			cfg_q.slew_step   <= RST_STEP;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEADZONE:  cfg_q.deadzone    <= cfg_data[SCALE_W-1:0];
				REG_DEBOUNCE:  cfg_q.debounce_ms <= cfg_data[DEB_W-1:0];
				REG_COLLISION: cfg_q.bumped_pct  <= cfg_data[SCALE_W-1:0];
				REG_NORMAL:    cfg_q.clear_pct   <= cfg_data[SCALE_W-1:0];
				REG_STEP:      cfg_q.slew_step   <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: valid under reset, payload captured on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1 <= req.req_type;
			now_s1  <= req.now_ms;
			rlev_s1 <= req.right_switch_level;
			llev_s1 <= req.left_switch_level;
			lraw_s1 <= req.left_stick_raw;
			rraw_s1 <= req.right_stick_raw;
		end
	end

	// Crosswise: the right switch sets the left target
	bdss_switch u_right_sw (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (poll_en),
		.level      (rlev_s1),
		.now_ms     (now_s1),
		.cfg        (cfg_q),
		.target_nxt (left_tgt_nxt)
	);

	bdss_switch u_left_sw (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (poll_en),
		.level      (llev_s1),
		.now_ms     (now_s1),
		.cfg        (cfg_q),
		.target_nxt (right_tgt_nxt)
	);

	bdss_scale u_left_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (poll_en),
		.target    (left_tgt_nxt),
		.step      (cfg_q.slew_step),
		.scale     (left_scale),
		.scale_nxt (left_scale_nxt),
		.fac       (left_fac)
	);

	bdss_scale u_right_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (poll_en),
		.target    (right_tgt_nxt),
		.step      (cfg_q.slew_step),
		.scale     (right_scale),
		.scale_nxt (right_scale_nxt),
		.fac       (right_fac)
	);

	// Stick items use the scales as they stand; tick results discard these drives
	bdss_drive u_left_drv (
		.raw      (lraw_s1),
		.deadzone (cfg_q.deadzone),
		.fac      (left_fac),
		.drive    (left_drv)
	);

	bdss_drive u_right_drv (
		.raw      (rraw_s1),
		.deadzone (cfg_q.deadzone),
		.fac      (right_fac),
		.drive    (right_drv)
	);

	// Result register: set on advance, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lscale_q <= left_scale_nxt;
			rscale_q <= right_scale_nxt;
			dvalid_q <= (type_s1 == REQ_JOY);
			ldrive_q <= (type_s1 == REQ_JOY) ? left_drv : '0;
			rdrive_q <= (type_s1 == REQ_JOY) ? right_drv : '0;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.left_scale_now  = lscale_q;
	assign res.right_scale_now = rscale_q;
	assign res.drive_valid     = dvalid_q;
	assign res.left_drive      = ldrive_q;
	assign res.right_drive     = rdrive_q;

	// Hold off requests only when both stages are full and the result is stalled
	`ASSERT_AT(a_ready_stall, clk, arst_n, !req.ready |-> (valid_s1 && res_valid_q && !res.ready))
	// Each advance presents its item, with the kind carried through
	`ASSERT_AT(a_adv_kind, clk, arst_n, advance |=> (res.valid && (res.drive_valid == $past(type_s1))))
	// Tick results carry no drive
	`ASSERT_NEVER(a_tick_drive, clk, arst_n, res.valid && !res.drive_valid && (res.left_drive != 0 || res.right_drive != 0))
	// Divide factors track their scales
	`ASSERT_AT(a_fac_track, clk, arst_n, (left_fac == FAC_W'(left_scale) * FAC_W'(RECIP)) && (right_fac == FAC_W'(right_scale) * FAC_W'(RECIP)))
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for bump_debounce_slew_speed_scaler_core: drives poll ticks and stick
// samples through the req/res channels and checks every result against a local model.
// Depends on bdss_pkg, bdss_req_if, bdss_res_if and the core itself.
module tb_top;
	import bdss_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int PERCENT      = 100;
	localparam int MAX_GAP      = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 1_000_000;

	// One request item as the bench sees it.
	typedef struct packed {
		logic               req_type;
		logic [TIME_W-1:0]  now_ms;
		logic               right_level;
		logic               left_level;
		logic [RAW_W-1:0]   left_raw;
		logic [RAW_W-1:0]   right_raw;
	} bump_req_t;

	// One result item: both scales plus the drive commands.
	typedef struct packed {
		logic [SCALE_W-1:0]      left_scale;
		logic [SCALE_W-1:0]      right_scale;
		logic                    drive_valid;
		logic signed [DRV_W-1:0] left_drive;
		logic signed [DRV_W-1:0] right_drive;
	} scale_res_t;

	// Tracks debounce state, targets and scales, and queues the result each accepted
	// request should produce. Results are matched strictly in order.
	class scaler_scoreboard;
		cfg_t               knobs;
		logic               right_kept, left_kept;
		logic [TIME_W-1:0]  right_stamp, left_stamp;
		logic [SCALE_W-1:0] left_tgt, right_tgt, left_scl, right_scl;
		scale_res_t         pending_outputs[$];
		int                 mismatches, results_seen;
		int                 polls, sticks, switch_changes, saturations;

		function new();
			knobs.deadzone    = RST_DEADZONE;
			knobs.debounce_ms = RST_DEBOUNCE;
			knobs.bumped_pct  = RST_COLLISION;
			knobs.clear_pct   = RST_NORMAL;
			knobs.slew_step   = RST_STEP;
			right_kept  = 1'b1;
			left_kept   = 1'b1;
			right_stamp = '0;
			left_stamp  = '0;
			left_tgt    = RST_NORMAL;
			right_tgt   = RST_NORMAL;
			left_scl    = RST_NORMAL;
			right_scl   = RST_NORMAL;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_DEADZONE:  knobs.deadzone    = data[SCALE_W-1:0];
			REG_DEBOUNCE:  knobs.debounce_ms = data[DEB_W-1:0];
			REG_COLLISION: knobs.bumped_pct  = data[SCALE_W-1:0];
			REG_NORMAL:    knobs.clear_pct   = data[SCALE_W-1:0];
			REG_STEP:      knobs.slew_step   = data[SCALE_W-1:0];
			default: ;
			endcase
		endfunction

		// Move one step toward the target, never overshooting it.
		function logic [SCALE_W-1:0] slew_toward(int cur, int tgt);
			int s;
			s = int'(knobs.slew_step);
			if (cur < tgt) begin
				cur += s;
				if (cur > tgt)
					cur = tgt;
			end else if (cur > tgt) begin
				if (cur < tgt + s)
					cur = tgt;
				else
					cur -= s;
			end
			return SCALE_W'(cur);
		endfunction

		// Centre, apply deadzone, scale by percent (truncating) and saturate.
		function logic signed [DRV_W-1:0] scaled_drive(logic [RAW_W-1:0] raw, int scl);
			int v, dz, p;
			v  = int'(raw) - int'(STICK_CENTRE);
			dz = int'(knobs.deadzone);
			if (v > -dz && v < dz)
				v = 0;
			p = (v * scl) / PERCENT;
			if (p > 127 || p < -128)
				saturations++;
			if (p > 127)
				p = 127;
			if (p < -128)
				p = -128;
			return DRV_W'(p);
		endfunction

		function void take_request(bump_req_t it);
			scale_res_t        r;
			logic [TIME_W-1:0] elapsed;
			r = '0;
			if (it.req_type == REQ_POLL) begin
				polls++;
				// right switch retargets the left side, and the other way round
				elapsed = it.now_ms - right_stamp;
				if (it.right_level != right_kept && elapsed > TIME_W'(knobs.debounce_ms)) begin
					right_kept  = it.right_level;
					right_stamp = it.now_ms;
					left_tgt    = it.right_level ? knobs.clear_pct : knobs.bumped_pct;
					switch_changes++;
				end
				elapsed = it.now_ms - left_stamp;
				if (it.left_level != left_kept && elapsed > TIME_W'(knobs.debounce_ms)) begin
					left_kept  = it.left_level;
					left_stamp = it.now_ms;
					right_tgt  = it.left_level ? knobs.clear_pct : knobs.bumped_pct;
					switch_changes++;
				end
				left_scl  = slew_toward(int'(left_scl), int'(left_tgt));
				right_scl = slew_toward(int'(right_scl), int'(right_tgt));
			end else begin
				sticks++;
				r.drive_valid = 1'b1;
				r.left_drive  = scaled_drive(it.left_raw, int'(left_scl));
				r.right_drive = scaled_drive(it.right_raw, int'(right_scl));
			end
			r.left_scale  = left_scl;
			r.right_scale = right_scl;
			pending_outputs.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
		endtask

		task match_result(scale_res_t got);
			scale_res_t want;
			results_seen++;
			if (pending_outputs.size() == 0) begin
				report_mismatch("result arrived with nothing outstanding");
				return;
			end
			want = pending_outputs.pop_front();
			if (got.left_scale !== want.left_scale)
				report_mismatch($sformatf("left_scale_now %0d, want %0d",
					got.left_scale, want.left_scale));
			if (got.right_scale !== want.right_scale)
				report_mismatch($sformatf("right_scale_now %0d, want %0d",
					got.right_scale, want.right_scale));
			if (got.drive_valid !== want.drive_valid)
				report_mismatch($sformatf("drive_valid %b, want %b",
					got.drive_valid, want.drive_valid));
			if (got.left_drive !== want.left_drive)
				report_mismatch($sformatf("left_drive %0d, want %0d",
					got.left_drive, want.left_drive));
			if (got.right_drive !== want.right_drive)
				report_mismatch($sformatf("right_drive %0d, want %0d",
					got.right_drive, want.right_drive));
		endtask

		task flush_leftovers();
			while (pending_outputs.size() != 0) begin
				void'(pending_outputs.pop_front());
				report_mismatch("expected result never arrived");
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bdss_req_if req_ch ();
	bdss_res_if res_ch ();

	bump_debounce_slew_speed_scaler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	scaler_scoreboard  sb;
	bit                send_quiet, recv_quiet;   // quiet: no idle cycles on that side
	logic [TIME_W-1:0] clock_ms;                 // running millisecond time for poll ticks
	logic              sent_right, sent_left;    // last switch levels sent
	int                settings_used;

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Hard stop in case a handshake hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding", sb.pending_outputs.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic int draw_gap(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	// Present one item at the falling edge and hold it until the rising edge that takes it.
	task automatic send_item(bump_req_t it);
		int gap;
		gap = draw_gap(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid              = 1'b1;
		req_ch.req_type           = it.req_type;
		req_ch.now_ms             = it.now_ms;
		req_ch.right_switch_level = it.right_level;
		req_ch.left_switch_level  = it.left_level;
		req_ch.left_stick_raw     = it.left_raw;
		req_ch.right_stick_raw    = it.right_raw;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.take_request(it);
	endtask

	// Stick bytes ride along on poll ticks but must be ignored.
	task automatic send_poll(logic [TIME_W-1:0] t, logic r, logic l);
		bump_req_t it;
		it.req_type    = REQ_POLL;
		it.now_ms      = t;
		it.right_level = r;
		it.left_level  = l;
		it.left_raw    = RAW_W'($urandom());
		it.right_raw   = RAW_W'($urandom());
		sent_right     = r;
		sent_left      = l;
		send_item(it);
	endtask

	// Time and switch levels are noise on a stick sample.
	task automatic send_stick(logic [RAW_W-1:0] lr, logic [RAW_W-1:0] rr);
		bump_req_t it;
		it.req_type    = REQ_JOY;
		it.now_ms      = $urandom();
		it.right_level = 1'($urandom());
		it.left_level  = 1'($urandom());
		it.left_raw    = lr;
		it.right_raw   = rr;
		send_item(it);
	endtask

	// Bias stick bytes toward the rails, the centre and the deadzone edges.
	function automatic logic [RAW_W-1:0] pick_raw();
		int dz;
		dz = int'(sb.knobs.deadzone);
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return RAW_W'(128 + dz);
		3: return RAW_W'(128 - dz);
		4: return RAW_W'(128 + dz - 1);
		5: return RAW_W'(128 - dz + 1);
		6: return RAW_W'($urandom_range(127, 129));
		default: return RAW_W'($urandom());
		endcase
	endfunction

	// Advance time by amounts clustered around the debounce window, with the odd
	// wild jump so the stamps wrap; flip each switch now and then.
	task automatic random_poll();
		int   deb;
		logic r, l;
		deb = int'(sb.knobs.debounce_ms);
		case ($urandom_range(0, 9))
		0, 1, 2: clock_ms += $urandom_range(0, deb);
		3, 4:    clock_ms += deb + $urandom_range(0, 2) - 1;
		5, 6, 7: clock_ms += deb + 1 + $urandom_range(0, 200);
		8:       clock_ms += $urandom();
		default: clock_ms  = $urandom();
		endcase
		r = ($urandom_range(0, 2) == 0) ? ~sent_right : sent_right;
		l = ($urandom_range(0, 2) == 0) ? ~sent_left : sent_left;
		send_poll(clock_ms, r, l);
	endtask

	task automatic run_random(int n);
		repeat (n) begin
			if ($urandom_range(0, 9) < 6)
				random_poll();
			else
				send_stick(pick_raw(), pick_raw());
		end
	endtask

	// Config writes; stray high bits on the narrow registers must be dropped.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'(value);
		if (idx != REG_DEBOUNCE)
			data[CFG_DATA_W-1:SCALE_W] = (CFG_DATA_W-SCALE_W)'($urandom());
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Wait for the block to go idle before touching its registers.
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic new_setting(int dz, int deb, int col, int norm, int stp);
		drain();
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_COLLISION, col);
		write_reg(REG_NORMAL, norm);
		write_reg(REG_STEP, stp);
		send_quiet = ($urandom_range(0, 3) == 0);
		recv_quiet = ($urandom_range(0, 3) == 0);
		settings_used++;
	endtask

	task automatic random_setting();
		int deb;
		deb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
		new_setting($urandom_range(0, 127), deb, $urandom_range(0, 127),
			$urandom_range(0, 127), $urandom_range(0, 127));
	endtask

	// Result side: stall at random, check every item taken.
	initial begin : result_side
		int         hold;
		scale_res_t got;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_gap(recv_quiet);
			@(negedge clk);
			if (hold > 0) begin
				res_ch.ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got.left_scale  = res_ch.left_scale_now;
			got.right_scale = res_ch.right_scale_now;
			got.drive_valid = res_ch.drive_valid;
			got.left_drive  = res_ch.left_drive;
			got.right_drive = res_ch.right_drive;
			sb.match_result(got);
		end
	end

	initial begin : stimulus
		sb = new();
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		req_ch.valid              = 1'b0;
		req_ch.req_type           = REQ_POLL;
		req_ch.now_ms             = '0;
		req_ch.right_switch_level = 1'b1;
		req_ch.left_switch_level  = 1'b1;
		req_ch.left_stick_raw     = '0;
		req_ch.right_stick_raw    = '0;
		clock_ms   = '0;
		sent_right = 1'b1;
		sent_left  = 1'b1;
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		settings_used = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset defaults: debounce boundary (equal is not enough), both
		// switches at once, slew down and settle on target.
		send_poll(32'd0, 1'b1, 1'b1);
		send_poll(32'd10, 1'b0, 1'b1);
		send_poll(32'd50, 1'b0, 1'b0);
		send_poll(32'd51, 1'b0, 1'b0);
		send_poll(32'd52, 1'b1, 1'b1);   // bounce inside the window: ignored
		send_poll(32'd60, 1'b0, 1'b0);
		send_poll(32'd60, 1'b0, 1'b0);
		send_poll(32'd60, 1'b0, 1'b0);
		send_poll(32'd61, 1'b0, 1'b0);
		// sticks: rails, centre, just inside and on the deadzone edge
		send_stick(8'd0, 8'd255);
		send_stick(8'd128, 8'd128);
		send_stick(8'd137, 8'd119);
		send_stick(8'd138, 8'd118);
		// release near the top of time, press again after the count wraps
		send_poll(32'hFFFF_FFF0, 1'b1, 1'b1);
		send_poll(32'h0000_0030, 1'b0, 1'b1);
		send_stick(8'd255, 8'd0);
		send_stick(8'd127, 8'd129);
		clock_ms = 32'h0000_0030;

		// Defaults again, no idling on either side.
		run_random(60);

		// Lower extremes: no deadzone, no debounce, finest step.
		new_setting(0, 0, 0, PERCENT, 1);
		run_random(60);

		// Upper extremes: widest deadzone and debounce, biggest in-range step.
		new_setting(127, 65535, PERCENT, 0, PERCENT);
		run_random(60);

		// Scales above 100 drive the products past the 8-bit range: saturate.
		new_setting(0, 0, 127, 127, 127);
		clock_ms += 1;
		send_poll(clock_ms, ~sent_right, ~sent_left);
		send_stick(8'd0, 8'd255);
		send_stick(8'd255, 8'd0);
		run_random(60);

		// Zero step: scales must stay put whatever the targets do.
		new_setting($urandom_range(0, 127), $urandom_range(0, 100), $urandom_range(0, 127),
			$urandom_range(0, 127), 0);
		run_random(50);

		// Writes to unused indexes must change nothing.
		drain();
		for (int i = int'(REG_STEP) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), $urandom());
		run_random(40);

		random_setting();
		run_random(60);
		random_setting();
		run_random(40);

		drain();
		sb.flush_leftovers();
		$display("Checked %0d results: %0d poll ticks with %0d debounced switch changes,",
			sb.results_seen, sb.polls, sb.switch_changes);
		$display("%0d stick samples (%0d saturated drives) over %0d register settings.",
			sb.sticks, sb.saturations, settings_used);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
